### hdl/mbap_frame_checker_with_lrc_unit_macros.svh
// Assertion macros used by the MBAP frame checker assertion module.
`ifndef MBAP_FRAME_CHECKER_WITH_LRC_UNIT_MACROS_SVH
`define MBAP_FRAME_CHECKER_WITH_LRC_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MBAPCHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define MBAPCHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/mbapchk_pkg.sv
// Types and constants of the MBAP frame checker.
package mbapchk_pkg;

  localparam int POS_W = 17;
  localparam int LEN_W = 16;

  localparam logic [15:0] MAX_LENGTH_RST = 16'd10000;
  localparam logic [15:0] MIN_LENGTH     = 16'd6;
  localparam logic [16:0] HEADER_TAIL    = 17'd6;

  localparam logic [16:0] POS_TID_HI  = 17'd0;
  localparam logic [16:0] POS_TID_LO  = 17'd1;
  localparam logic [16:0] POS_LEN_HI  = 17'd4;
  localparam logic [16:0] POS_LEN_LO  = 17'd5;
  localparam logic [16:0] POS_ADDR_HI = 17'd8;
  localparam logic [16:0] POS_ADDR_LO = 17'd9;
  localparam logic [16:0] POS_RET_HI  = 17'd10;
  localparam logic [16:0] POS_RET_LO  = 17'd11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SIZE_ERR  = 2'd1,
    ST_CHECK_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] func_addr;
    logic [15:0] return_value;
    logic [15:0] transaction_id;
  } result_t;

endpackage

### hdl/mbapchk_parser.sv
// Frame state, header capture, length check and LRC compare for one byte.
module mbapchk_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  logic [15:0]           max_length,
  output mbapchk_pkg::result_t  res
);
  import mbapchk_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             recv_r, recv_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [15:0]      ret_r, ret_nxt;
  logic [15:0]      tid_r, tid_nxt;

  logic             active;
  logic             end_hit;
  logic [POS_W-1:0] pos_cur;
  logic [LEN_W-1:0] len_cur;
  logic [7:0]       sum_cur;
  logic [15:0]      addr_cur, ret_cur, tid_cur;
  logic [7:0]       expect_b;

  always_comb begin
    active   = frame_start | recv_r;
    pos_cur  = frame_start ? '0 : pos_r;
    len_cur  = frame_start ? '0 : len_r;
    sum_cur  = frame_start ? '0 : sum_r;
    addr_cur = frame_start ? '0 : addr_r;
    ret_cur  = frame_start ? '0 : ret_r;
    tid_cur  = frame_start ? '0 : tid_r;
    end_hit  = (pos_cur > POS_LEN_LO) && (pos_cur == ({1'b0, len_cur} + HEADER_TAIL));
    expect_b = 8'(8'd0 - sum_cur);

    pos_nxt  = pos_r;
    recv_nxt = recv_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    addr_nxt = addr_r;
    ret_nxt  = ret_r;
    tid_nxt  = tid_r;

    res.valid          = 1'b0;
    res.status         = ST_OK;
    res.func_addr      = addr_cur;
    res.return_value   = ret_cur;
    res.transaction_id = tid_cur;

    if (active) begin
      len_nxt  = len_cur;
      addr_nxt = addr_cur;
      ret_nxt  = ret_cur;
      tid_nxt  = tid_cur;
      pos_nxt  = pos_cur;
      sum_nxt  = sum_cur;
      recv_nxt = 1'b1;
      if (end_hit) begin
        recv_nxt   = 1'b0;
        res.valid  = 1'b1;
        res.status = (expect_b == rx_byte) ? ST_OK : ST_CHECK_ERR;
      end else begin
        sum_nxt = 8'(sum_cur + rx_byte);
        case (pos_cur)
          POS_TID_HI:  tid_nxt  = {rx_byte, 8'd0};
          POS_TID_LO:  tid_nxt  = {tid_cur[15:8], rx_byte};
          POS_LEN_HI:  len_nxt  = {rx_byte, 8'd0};
          POS_LEN_LO:  len_nxt  = {len_cur[15:8], rx_byte};
          POS_ADDR_HI: addr_nxt = {rx_byte, 8'd0};
          POS_ADDR_LO: addr_nxt = {addr_cur[15:8], rx_byte};
          POS_RET_HI:  ret_nxt  = {rx_byte, 8'd0};
          POS_RET_LO:  ret_nxt  = {ret_cur[15:8], rx_byte};
          default: ;
        endcase
        pos_nxt = POS_W'(pos_cur + 1'b1);
        if ((pos_cur == POS_LEN_LO) &&
            ((len_nxt < MIN_LENGTH) || (len_nxt > max_length))) begin
          recv_nxt           = 1'b0;
          res.valid          = 1'b1;
          res.status         = ST_SIZE_ERR;
          res.func_addr      = '0;
          res.return_value   = '0;
          res.transaction_id = tid_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      recv_r <= 1'b0;
      len_r  <= '0;
      sum_r  <= '0;
      addr_r <= '0;
      ret_r  <= '0;
      tid_r  <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      recv_r <= recv_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      addr_r <= addr_nxt;
      ret_r  <= ret_nxt;
      tid_r  <= tid_nxt;
    end
  end

endmodule

### hdl/mbap_frame_checker_with_lrc_unit.sv
// MBAP frame checker with LRC: input register, frame parser, result register.
// out_tvalid rises once the request's byte has passed the input register and the result register.
// Throughput: one byte per cycle unless a waiting result is stalled; an empty input register still takes a byte then.
// Reset (rst_n low, synchronous): frame state idle, registers empty, max_length 10000.
// Config writes are always taken (cfg_ready high).
module mbap_frame_checker_with_lrc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] func_addr, [31:16] return_value,
                                  // [47:32] transaction_id
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // max_length
);
  import mbapchk_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic [15:0] max_len_r;
  logic        out_v_r;
  result_t     out_r;
  result_t     res;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LENGTH_RST;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  mbapchk_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .rx_byte     (in_byte_r),
    .frame_start (in_start_r),
    .max_length  (max_len_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid && out_free) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.transaction_id, out_r.return_value, out_r.func_addr};
  assign out_tuser  = out_r.status;

endmodule

### hdl/mbapchk_checker.sv
// Port-level assertions for the MBAP frame checker, bound to the top level.
`include "mbap_frame_checker_with_lrc_unit_macros.svh"

module mbapchk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import mbapchk_pkg::*;

  `MBAPCHK_IMPLY(a_out_hold, out_tvalid && !out_tready, ##1 (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")
  `MBAPCHK_IMPLY(a_status_code, out_tvalid, (out_tuser == ST_OK) || (out_tuser == ST_SIZE_ERR) || (out_tuser == ST_CHECK_ERR), "bad status code")
  `MBAPCHK_IMPLY(a_size_err_zero, out_tvalid && (out_tuser == ST_SIZE_ERR), out_tdata[31:0] == 32'd0, "size error carries header fields")
  `MBAPCHK_ASSERT(a_result_cause, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2), "result without a request two cycles earlier")

endmodule

bind mbap_frame_checker_with_lrc_unit mbapchk_checker u_mbapchk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/tb.sv
// Self-checking testbench for the MBAP frame checker: directed frames, then random frames.
`timescale 1ns / 100ps

module tb;
  import mbapchk_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [15:0] func_addr;
    logic [15:0] return_value;
    logic [15:0] transaction_id;
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       start;
    logic       known;
    verdict_t   want;
  } dir_row_t;

  localparam verdict_t NO_VERDICT = '{ST_OK, 16'h0000, 16'h0000, 16'h0000};
  localparam int DIR_ROWS = 28;

  // rx, frame_start, verdict typed in, verdict
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{8'h5A, 1'b0, 1'b0, NO_VERDICT},
    '{8'hAA, 1'b1, 1'b0, NO_VERDICT},
    '{8'hBB, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF, 1'b1, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h05, 1'b0, 1'b1, '{ST_SIZE_ERR, 16'h0000, 16'h0000, 16'hFF00}},
    '{8'h12, 1'b1, 1'b0, NO_VERDICT},
    '{8'h34, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF, 1'b0, 1'b1, '{ST_SIZE_ERR, 16'h0000, 16'h0000, 16'h1234}},
    '{8'h00, 1'b1, 1'b0, NO_VERDICT},
    '{8'h01, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h06, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'hAB, 1'b0, 1'b0, NO_VERDICT},
    '{8'hCD, 1'b0, 1'b0, NO_VERDICT},
    '{8'h12, 1'b0, 1'b0, NO_VERDICT},
    '{8'h34, 1'b0, 1'b0, NO_VERDICT},
    '{8'h3B, 1'b0, 1'b0, NO_VERDICT}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic [0:0]  in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [15:0] cfg_data   = 16'h0000;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_ready;

  // typed-in verdict travels beside the request it belongs to
  logic        req_known = 1'b0;
  verdict_t    req_want  = NO_VERDICT;

  bit          sender_idle_on = 1'b1;
  bit          recv_idle_on   = 1'b1;
  bit          long_hold      = 1'b0;
  logic [15:0] cur_lim        = MAX_LENGTH_RST;
  int          mismatch_count = 0;

  // frame parser state of the predictor
  logic [15:0] lim_copy;
  logic        frm_active;
  logic [16:0] frm_pos;
  logic [15:0] frm_len;
  logic [7:0]  frm_sum;
  logic [15:0] frm_addr;
  logic [15:0] frm_ret;
  logic [15:0] frm_tid;
  verdict_t    pending_verdicts[$];

  always #5 clk = ~clk;

  mbap_frame_checker_with_lrc_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic bit parse_frame_byte(input logic [7:0] b, input logic s,
                                          output verdict_t v);
    logic [16:0] pos;
    v = NO_VERDICT;
    if (s) begin
      frm_active = 1'b1;
      frm_pos    = '0;
      frm_sum    = '0;
      frm_len    = '0;
      frm_addr   = '0;
      frm_ret    = '0;
      frm_tid    = '0;
    end else if (!frm_active) begin
      return 1'b0;
    end
    pos = frm_pos;
    if (pos > POS_LEN_LO && pos == {1'b0, frm_len} + HEADER_TAIL) begin
      frm_active = 1'b0;
      v = '{((8'h00 - frm_sum) == b) ? ST_OK : ST_CHECK_ERR, frm_addr, frm_ret, frm_tid};
      return 1'b1;
    end
    frm_sum = frm_sum + b;
    case (pos)
      POS_TID_HI:  frm_tid  = {b, 8'h00};
      POS_TID_LO:  frm_tid  = {frm_tid[15:8], b};
      POS_LEN_HI:  frm_len  = {b, 8'h00};
      POS_LEN_LO:  frm_len  = {frm_len[15:8], b};
      POS_ADDR_HI: frm_addr = {b, 8'h00};
      POS_ADDR_LO: frm_addr = {frm_addr[15:8], b};
      POS_RET_HI:  frm_ret  = {b, 8'h00};
      POS_RET_LO:  frm_ret  = {frm_ret[15:8], b};
      default: ;
    endcase
    frm_pos = pos + 17'd1;
    if (pos == POS_LEN_LO && (frm_len < MIN_LENGTH || frm_len > lim_copy)) begin
      frm_active = 1'b0;
      v = '{ST_SIZE_ERR, 16'h0000, 16'h0000, frm_tid};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    verdict_t got_v;
    bit       got;
    if (!rst_n) begin
      lim_copy   <= MAX_LENGTH_RST;
      frm_active <= 1'b0;
      frm_pos    <= '0;
      frm_len    <= '0;
      frm_sum    <= '0;
      frm_addr   <= '0;
      frm_ret    <= '0;
      frm_tid    <= '0;
    end else begin
      if (cfg_valid && cfg_ready)
        lim_copy = cfg_data;
      if (in_tvalid && in_tready) begin
        got = parse_frame_byte(in_tdata, in_tuser[0], got_v);
        if (req_known)
          pending_verdicts.push_back(req_want);
        else if (got)
          pending_verdicts.push_back(got_v);
      end
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with none expected: status %0d, data %h", out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          v = pending_verdicts.pop_front();
          if (out_tuser !== v.status) begin
            $error("status: expected %0d, actual %0d", v.status, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[15:0] !== v.func_addr) begin
            $error("func_addr: expected %h, actual %h", v.func_addr, out_tdata[15:0]);
            mismatch_count++;
          end
          if (out_tdata[31:16] !== v.return_value) begin
            $error("return_value: expected %h, actual %h", v.return_value, out_tdata[31:16]);
            mismatch_count++;
          end
          if (out_tdata[47:32] !== v.transaction_id) begin
            $error("transaction_id: expected %h, actual %h",
                   v.transaction_id, out_tdata[47:32]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s, input logic known,
                           input verdict_t want);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    req_known <= known;
    req_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] value);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_lim = value;
  endtask

  function automatic logic [15:0] pick_length();
    int k;
    int hi;
    k  = $urandom_range(0, 19);
    hi = (cur_lim < 6) ? 6 : ((cur_lim > 24) ? 24 : int'(cur_lim));
    if (k < 12)
      return 16'($urandom_range(6, hi));
    if (k < 14)
      return (cur_lim <= 64) ? cur_lim : cur_lim + 16'd1;
    if (k < 15)
      return cur_lim + 16'd1;
    if (k < 18)
      return 16'($urandom_range(0, 5));
    if (cur_lim > 16'hF000)
      return cur_lim + 16'd1;
    return 16'hFFFF - 16'($urandom_range(0, 255));
  endfunction

  // one frame with random content; bad check byte or early cut now and then
  task automatic frame_out(input logic [15:0] l, input bit may_cut, output int count);
    logic [7:0] fb[$];
    logic [7:0] acc;
    logic [7:0] b;
    int         last;
    int         n;
    int         i;
    acc  = 8'h00;
    last = (l >= MIN_LENGTH && l <= cur_lim) ? int'(l) + 6 : 5;
    for (i = 0; i <= last; i++) begin
      if (i == 4)
        b = l[15:8];
      else if (i == 5)
        b = l[7:0];
      else if (i == last && last > 5)
        b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00 - acc;
      else
        b = 8'($urandom);
      acc = acc + b;
      fb.push_back(b);
    end
    n = fb.size();
    if (may_cut && $urandom_range(0, 9) == 0)
      n = $urandom_range(1, n - 1);
    for (i = 0; i < n; i++)
      send_byte(fb[i], i == 0, 1'b0, NO_VERDICT);
    count = n;
  endtask

  task automatic run_frames(input int target);
    int sent;
    int cnt;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0, NO_VERDICT);
      frame_out(pick_length(), 1'b1, cnt);
      sent += cnt;
    end
  endtask

  initial begin
    int cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIR_TABLE[i].rx, DIR_TABLE[i].start, DIR_TABLE[i].known, DIR_TABLE[i].want);
    run_frames(80);
    cfg_write(16'd6);
    run_frames(60);
    cfg_write(16'd3);
    long_hold = 1'b1;
    run_frames(60);
    cfg_write(16'hFFFF);
    sender_idle_on = 1'b0;
    frame_out(16'd48, 1'b0, cnt);
    sender_idle_on = 1'b1;
    run_frames(60);
    cfg_write(16'($urandom_range(6, 40)));
    sender_idle_on = 1'b0;
    recv_idle_on   = 1'b0;
    run_frames(90);
    wait_quiet();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mbapchk_pkg.sv
hdl/mbapchk_parser.sv
hdl/mbap_frame_checker_with_lrc_unit.sv
hdl/mbapchk_checker.sv
tb/tb.sv
